// ----- src/frp_pkg.sv -----
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_A_W = 2;

  localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hFF;

  // register indexes on the configuration port
  localparam logic [CFG_A_W-1:0] REG_OWN_ADDR  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_START     = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_END       = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_MAX_LEN   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_LEN,
    ST_DATA,
    ST_END,
    ST_CHK,
    ST_RD,     // read address presented to the payload RAM
    ST_LD,     // RAM data valid, load into output register
    ST_EMPTY   // emit the single result of a zero-length frame
  } frame_state_t;

endpackage

`default_nettype wire

// ----- src/frp_ram.sv -----
// ----------------------------------------------------------------------------
// frp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/framed_packet_receiver_core.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receiver_core
// Start/address/length/payload/end/checksum frame receiver with XOR check.
// Payload bytes are buffered in a RAM and replayed as a run of items.
// ----------------------------------------------------------------------------
// Input bytes are taken while in_ready is high; the checksum byte of a good
// frame leads via the read and load states to its first item. Each payload
// item replays through the read/load state pair (RAM read, then output
// register load, which waits on a stall); input is held off for the whole
// replay. An empty frame gives one item. Reset (rst, synchronous) returns to
// idle, resets state and config registers to defaults; payload RAM and output data stay.
`default_nettype none

module framed_packet_receiver_core #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [frp_pkg::CFG_A_W-1:0]   cfg_index,
  input  wire logic [frp_pkg::BYTE_W-1:0]    cfg_data,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [frp_pkg::BYTE_W-1:0]    rx_byte,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [frp_pkg::BYTE_W-1:0]    payload_byte,
  output logic      [frp_pkg::IDX_W-1:0]     payload_index,
  output logic      [frp_pkg::LEN_W-1:0]     frame_length,
  output logic                               has_data,
  output logic                               last
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [frp_pkg::BYTE_W-1:0] MAX_PAYLOAD_B = frp_pkg::BYTE_W'(MAX_PAYLOAD);

  // configuration registers
  logic [frp_pkg::BYTE_W-1:0] own_address;
  logic [frp_pkg::BYTE_W-1:0] start_marker;
  logic [frp_pkg::BYTE_W-1:0] end_marker;
  logic [frp_pkg::LEN_W-1:0]  max_length;

  frp_pkg::frame_state_t state, state_next;
  logic [frp_pkg::BYTE_W-1:0] csum, csum_next;
  logic [frp_pkg::LEN_W-1:0]  rem, rem_next;
  logic [frp_pkg::LEN_W-1:0]  wr_pos, wr_pos_next;
  logic [frp_pkg::LEN_W-1:0]  len, len_next;
  logic [frp_pkg::LEN_W-1:0]  rd_idx, rd_idx_next;

  logic                       in_acc;
  logic                       slot_free;
  logic                       ram_we;
  logic [frp_pkg::BYTE_W-1:0] ram_rdata;
  logic                       load_data;
  logic                       load_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= '0;
      start_marker <= 8'h02;
      end_marker   <= 8'h03;
      max_length   <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        frp_pkg::REG_OWN_ADDR: own_address  <= cfg_data;
        frp_pkg::REG_START:    start_marker <= cfg_data;
        frp_pkg::REG_END:      end_marker   <= cfg_data;
        frp_pkg::REG_MAX_LEN:  max_length   <= cfg_data[frp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = !(state inside {frp_pkg::ST_RD, frp_pkg::ST_LD, frp_pkg::ST_EMPTY});
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign ram_we    = in_acc && (state == frp_pkg::ST_DATA);

  frp_ram #(
    .WIDTH (frp_pkg::BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(wr_pos)),
    .wdata (rx_byte),
    .raddr (AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next  = state;
    csum_next   = csum;
    rem_next    = rem;
    wr_pos_next = wr_pos;
    len_next    = len;
    rd_idx_next = rd_idx;
    load_data   = 1'b0;
    load_empty  = 1'b0;
    case (state)
      frp_pkg::ST_ADDR: begin
        if (in_acc) begin
          if (rx_byte == own_address || rx_byte == frp_pkg::BROADCAST_ADDR) begin
            csum_next  = csum ^ own_address;
            state_next = frp_pkg::ST_LEN;
          end else begin
            state_next = frp_pkg::ST_IDLE;
          end
        end
      end
      frp_pkg::ST_LEN: begin
        if (in_acc) begin
          if (rx_byte > {2'b00, max_length} || rx_byte > MAX_PAYLOAD_B) begin
            state_next = frp_pkg::ST_IDLE;
          end else begin
            rem_next   = rx_byte[frp_pkg::LEN_W-1:0];
            len_next   = rx_byte[frp_pkg::LEN_W-1:0];
            csum_next  = csum ^ rx_byte;
            state_next = (rx_byte == '0) ? frp_pkg::ST_END : frp_pkg::ST_DATA;
          end
        end
      end
      frp_pkg::ST_DATA: begin
        if (in_acc) begin
          csum_next   = csum ^ rx_byte;
          wr_pos_next = wr_pos + 6'd1;
          rem_next    = rem - 6'd1;
          if (rem == 6'd1) begin
            state_next = frp_pkg::ST_END;
          end
        end
      end
      frp_pkg::ST_END: begin
        if (in_acc) begin
          if (rx_byte == end_marker) begin
            csum_next  = csum ^ end_marker;
            state_next = frp_pkg::ST_CHK;
          end else begin
            state_next = frp_pkg::ST_IDLE;
          end
        end
      end
      frp_pkg::ST_CHK: begin
        if (in_acc) begin
          rd_idx_next = '0;
          if (rx_byte != csum) begin
            state_next = frp_pkg::ST_IDLE;
          end else if (len == '0) begin
            state_next = frp_pkg::ST_EMPTY;
          end else begin
            state_next = frp_pkg::ST_RD;
          end
        end
      end
      frp_pkg::ST_RD: begin
        state_next = frp_pkg::ST_LD;
      end
      frp_pkg::ST_LD: begin
        // RAM data reflects rd_idx, which holds while the output is stalled
        if (slot_free) begin
          load_data = 1'b1;
          if (rd_idx == len - 6'd1) begin
            state_next = frp_pkg::ST_IDLE;
          end else begin
            rd_idx_next = rd_idx + 6'd1;
            state_next  = frp_pkg::ST_RD;
          end
        end
      end
      frp_pkg::ST_EMPTY: begin
        if (slot_free) begin
          load_empty = 1'b1;
          state_next = frp_pkg::ST_IDLE;
        end
      end
      default: begin
        if (in_acc) begin
          if (rx_byte == start_marker) begin
            wr_pos_next = '0;
            csum_next   = start_marker;
            state_next  = frp_pkg::ST_ADDR;
          end else begin
            state_next = frp_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= frp_pkg::ST_IDLE;
      csum   <= '0;
      rem    <= '0;
      wr_pos <= '0;
      len    <= '0;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      csum   <= csum_next;
      rem    <= rem_next;
      wr_pos <= wr_pos_next;
      len    <= len_next;
      rd_idx <= rd_idx_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_data || load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_data) begin
      payload_byte  <= ram_rdata;
      payload_index <= rd_idx[frp_pkg::IDX_W-1:0];
      frame_length  <= len;
      has_data      <= 1'b1;
      last          <= (rd_idx == len - 6'd1);
    end else if (load_empty) begin
      payload_byte  <= '0;
      payload_index <= '0;
      frame_length  <= '0;
      has_data      <= 1'b0;
      last          <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_ld_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == frp_pkg::ST_LD) |-> (rd_idx < len))
    else $error("replay index beyond frame length");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (state == frp_pkg::ST_DATA) |-> (rem != '0 && wr_pos < len))
    else $error("payload counters out of step");

  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_data) |-> (last && frame_length == '0))
    else $error("empty-frame item malformed");

  a_replay_holds_input: assert property (@(posedge clk) disable iff (rst)
    (state == frp_pkg::ST_RD) |=> (state == frp_pkg::ST_LD && !in_ready))
    else $error("replay sequence broken");
`endif

endmodule

`default_nettype wire
